### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared widths, register indexes and state types for the crossing table.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W   = 32;
    localparam int SLOT_W    = 6;
    localparam int SLOT_SPAN = 1 << SLOT_W;
    localparam int QUO_STEPS = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LON = 1'b1;

    localparam logic MODE_SEGMENT = 1'b0;
    localparam logic MODE_CLEAR   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_WAIT,
        S_FIN
    } top_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_ITER
    } div_state_t;

    typedef struct packed {
        logic                toggle;
        logic                hit;
        logic                need_div;
        logic                lat_neg;
    } seg_class_t;

endpackage

### rtl/pip_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pip_divider.sv
// ----------------------------------------------------------------------------
// Interpolation divider
// Multiplies magnitude by offset once, then restores one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pip_divider
    import pip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [COORD_W-1:0] mag,
    input  logic [COORD_W-1:0] off,
    input  logic [COORD_W-1:0] span,
    output logic               done,
    output logic [COORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_STEPS);

    div_state_t           state_reg;
    div_state_t           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic [COORD_W-1:0]   low_reg;
    logic                 done_reg;
    logic [2*COORD_W-1:0] product;
    logic [COORD_W:0]     trial;
    logic                 fits;
    logic                 last_step;

    assign product   = mag * off;
    assign trial     = {rem_reg, low_reg[COORD_W-1]};
    assign fits      = trial >= {1'b0, span};
    assign last_step = cnt_reg == CNT_W'(QUO_STEPS - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (go)
                begin
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                state_next = D_ITER;
            end
            D_ITER:
            begin
                if (last_step)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_ITER) && last_step;
            if (state_reg == D_ITER)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_MUL)
        begin
            rem_reg <= product[2*COORD_W-1:COORD_W];
            low_reg <= product[COORD_W-1:0];
        end
        else if (state_reg == D_ITER)
        begin
            rem_reg <= fits ? COORD_W'(trial - {1'b0, span}) : trial[COORD_W-1:0];
            low_reg <= {low_reg[COORD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

### rtl/point_in_polygon_crossing_table_top.sv
// ----------------------------------------------------------------------------
// Point-in-polygon crossing table
// Tracks crossing parity and border marks per area slot for one query point.
// ----------------------------------------------------------------------------
// Items needing no interpolation pass from start through the prep and finish
//   states to done; when the segment straddles the query latitude the divider
//   (one multiply plus 32 restoring divide steps) runs in a wait state between.
// One item at a time: a new start is taken only when idle; busy stays high until done.
// Results are strobed for one cycle on done and cannot be stalled.
// Reset clears the query point and all parity and border marks at once.
module point_in_polygon_crossing_table_top
    import pip_pkg::*;
#(
    parameter int unsigned AREA_SLOTS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic [SLOT_W-1:0]         area_slot,
    input  logic signed [COORD_W-1:0] west_lon,
    input  logic signed [COORD_W-1:0] west_lat,
    input  logic signed [COORD_W-1:0] east_lon,
    input  logic signed [COORD_W-1:0] east_lat,
    output logic                      done,
    output logic [SLOT_W-1:0]         slot_out,
    output logic                      crossing_parity,
    output logic                      on_border,
    output logic                      in_area
);

    localparam int DEPTH  = (AREA_SLOTS < SLOT_SPAN) ? AREA_SLOTS : SLOT_SPAN;
    localparam int ADDR_W = $clog2(DEPTH);

    top_state_t                state_reg;
    top_state_t                state_next;
    logic signed [COORD_W-1:0] query_lat_reg;
    logic signed [COORD_W-1:0] query_lon_reg;
    logic                      mode_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic signed [COORD_W-1:0] wlon_reg;
    logic signed [COORD_W-1:0] wlat_reg;
    logic signed [COORD_W-1:0] elon_reg;
    logic signed [COORD_W-1:0] elat_reg;
    seg_class_t                cls_reg;
    seg_class_t                cls_next;
    logic [COORD_W-1:0]        mag_reg;
    logic [COORD_W-1:0]        off_reg;
    logic [COORD_W-1:0]        span_reg;
    logic [DEPTH-1:0]          valid_reg;
    logic                      done_reg;
    logic [SLOT_W-1:0]         slot_out_reg;
    logic                      parity_out_reg;
    logic                      border_out_reg;

    logic                      accept;
    logic                      in_range;
    logic                      active;
    logic                      div_go;
    logic                      div_done;
    logic [COORD_W-1:0]        quotient;
    logic [ADDR_W-1:0]         addr;
    logic [1:0]                ram_rdata;
    logic [1:0]                entry;
    logic                      ram_we;
    logic [1:0]                ram_wdata;
    logic                      fin;
    logic signed [COORD_W:0]   dlat;
    logic [COORD_W:0]          mag_wide;
    logic [COORD_W:0]          off_wide;
    logic [COORD_W:0]          span_wide;
    logic signed [COORD_W+1:0] interp;
    logic signed [COORD_W+1:0] lat_wide;
    logic                      toggle;
    logic                      hit;
    logic                      new_parity;
    logic                      new_border;

    assign accept   = start && !busy;
    assign in_range = 32'(slot_reg) < AREA_SLOTS;
    assign active   = (mode_reg == MODE_SEGMENT) && in_range;
    assign addr     = slot_reg[ADDR_W-1:0];

    // Classify the segment against the query point.
    always_comb
    begin
        cls_next = '0;
        if (elon_reg > query_lon_reg)
        begin
            if (wlon_reg < query_lon_reg)
            begin
                if (wlat_reg < query_lat_reg && elat_reg < query_lat_reg)
                begin
                    cls_next.toggle = 1'b1;
                end
                else if (wlat_reg < query_lat_reg || elat_reg < query_lat_reg)
                begin
                    cls_next.need_div = 1'b1;
                end
                else if (wlat_reg == query_lat_reg && elat_reg == query_lat_reg)
                begin
                    cls_next.hit = 1'b1;
                end
            end
            else if (wlon_reg == query_lon_reg)
            begin
                if (wlat_reg < query_lat_reg)
                begin
                    cls_next.toggle = 1'b1;
                end
                else if (wlat_reg == query_lat_reg)
                begin
                    cls_next.hit = 1'b1;
                end
            end
        end
        else if (elon_reg == query_lon_reg)
        begin
            if (elat_reg == query_lat_reg)
            begin
                cls_next.hit = 1'b1;
            end
            else if (wlon_reg == elon_reg)
            begin
                if ((wlat_reg <= query_lat_reg && query_lat_reg <= elat_reg) ||
                    (elat_reg <= query_lat_reg && query_lat_reg <= wlat_reg))
                begin
                    cls_next.hit = 1'b1;
                end
            end
        end
        cls_next.lat_neg = dlat[COORD_W];
    end

    assign dlat      = {elat_reg[COORD_W-1], elat_reg} - {wlat_reg[COORD_W-1], wlat_reg};
    assign mag_wide  = dlat[COORD_W] ? (COORD_W+1)'(-dlat) : dlat;
    assign off_wide  = {query_lon_reg[COORD_W-1], query_lon_reg}
                       - {wlon_reg[COORD_W-1], wlon_reg};
    assign span_wide = {elon_reg[COORD_W-1], elon_reg} - {wlon_reg[COORD_W-1], wlon_reg};

    assign interp   = cls_reg.lat_neg
                      ? {{2{wlat_reg[COORD_W-1]}}, wlat_reg} - {2'b00, quotient}
                      : {{2{wlat_reg[COORD_W-1]}}, wlat_reg} + {2'b00, quotient};
    assign lat_wide = {{2{query_lat_reg[COORD_W-1]}}, query_lat_reg};

    assign toggle = cls_reg.toggle || (cls_reg.need_div && interp < lat_wide);
    assign hit    = cls_reg.hit || (cls_reg.need_div && interp == lat_wide);

    assign entry      = valid_reg[addr] ? ram_rdata : 2'b00;
    assign new_parity = entry[0] ^ toggle;
    assign new_border = entry[1] | hit;
    assign ram_wdata  = {new_border, new_parity};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (active && cls_next.need_div)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_go = 1'b0;
        fin    = 1'b0;
        ram_we = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_PREP:
            begin
                div_go = active && cls_next.need_div;
            end
            S_WAIT:
            begin
            end
            S_FIN:
            begin
                fin    = 1'b1;
                ram_we = active;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            query_lat_reg <= '0;
            query_lon_reg <= '0;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_QUERY_LAT: query_lat_reg <= cfg_data;
                    REG_QUERY_LON: query_lon_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (fin && mode_reg == MODE_CLEAR)
            begin
                valid_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            slot_reg <= area_slot;
            wlon_reg <= west_lon;
            wlat_reg <= west_lat;
            elon_reg <= east_lon;
            elat_reg <= east_lat;
        end
        if (state_reg == S_PREP)
        begin
            cls_reg  <= cls_next;
            mag_reg  <= mag_wide[COORD_W-1:0];
            off_reg  <= off_wide[COORD_W-1:0];
            span_reg <= span_wide[COORD_W-1:0];
        end
        if (fin)
        begin
            slot_out_reg   <= slot_reg;
            parity_out_reg <= active && new_parity;
            border_out_reg <= active && new_border;
        end
    end

    pip_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .mag      (mag_reg),
        .off      (off_reg),
        .span     (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    pip_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign slot_out        = slot_out_reg;
    assign crossing_parity = parity_out_reg;
    assign on_border       = border_out_reg;
    assign in_area         = parity_out_reg || border_out_reg;

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted without going busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");
`endif

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Crossing table testbench
// Drives border segments and clear commands into the point-in-polygon
// crossing table and checks every strobed area status against a behavioral
// predictor of the per-slot parity and border marks. One transfer per item:
// directed corner cases at a fixed query point, then random polygons,
// special edges and noise under several query points, the extremes included.
// ----------------------------------------------------------------------------
module tb
    import pip_pkg::*;
();

    localparam int unsigned AREA_SLOTS = 64;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned PHASES = 7;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              parity;
        logic              border;
        logic              in_area;
    } area_status_t;

    class crossing_scoreboard_t;
        bit parity_bits[SLOT_SPAN];
        bit border_bits[SLOT_SPAN];
        logic signed [COORD_W-1:0] query_lat;
        logic signed [COORD_W-1:0] query_lon;
        area_status_t expected_status[$];
        int errors;

        function new();
            query_lat = '0;
            query_lon = '0;
            errors = 0;
        endfunction

        function void set_query(logic signed [COORD_W-1:0] lat,
                                logic signed [COORD_W-1:0] lon);
            query_lat = lat;
            query_lon = lon;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void add_expected(area_status_t st);
            expected_status.insert(expected_status.size(), st);
        endfunction

        function longint lat_at_query(longint wlo, longint wla, longint elo,
                                      longint ela, longint lon);
            longint dlat;
            longint unsigned mag;
            longint unsigned off;
            longint unsigned span;
            longint unsigned quo;
            dlat = ela - wla;
            mag = (dlat < 0) ? -dlat : dlat;
            off = lon - wlo;
            span = elo - wlo;
            quo = (mag * off) / span;
            return (dlat < 0) ? wla - longint'(quo) : wla + longint'(quo);
        endfunction

        function void note_item(logic m, logic [SLOT_W-1:0] slot,
                                logic signed [COORD_W-1:0] west_lon,
                                logic signed [COORD_W-1:0] west_lat,
                                logic signed [COORD_W-1:0] east_lon,
                                logic signed [COORD_W-1:0] east_lat);
            area_status_t st;
            longint lat;
            longint lon;
            longint wlo;
            longint wla;
            longint elo;
            longint ela;
            longint r;
            bit toggle;
            bit hit;
            st.slot = slot;
            st.parity = 1'b0;
            st.border = 1'b0;
            st.in_area = 1'b0;
            toggle = 1'b0;
            hit = 1'b0;
            lat = query_lat;
            lon = query_lon;
            wlo = west_lon;
            wla = west_lat;
            elo = east_lon;
            ela = east_lat;
            if (m == MODE_CLEAR)
            begin
                foreach (parity_bits[i])
                begin
                    parity_bits[i] = 1'b0;
                    border_bits[i] = 1'b0;
                end
                add_expected(st);
                return;
            end
            if (slot >= AREA_SLOTS)
            begin
                add_expected(st);
                return;
            end
            if (elo > lon)
            begin
                if (wlo < lon)
                begin
                    if (wla < lat && ela < lat)
                    begin
                        toggle = 1'b1;
                    end
                    else if (wla < lat || ela < lat)
                    begin
                        r = lat_at_query(wlo, wla, elo, ela, lon);
                        if (r < lat)
                            toggle = 1'b1;
                        else if (r == lat)
                            hit = 1'b1;
                    end
                    else if (wla == lat && ela == lat)
                    begin
                        hit = 1'b1;
                    end
                end
                else if (wlo == lon)
                begin
                    if (wla < lat)
                        toggle = 1'b1;
                    else if (wla == lat)
                        hit = 1'b1;
                end
            end
            else if (elo == lon)
            begin
                if (ela == lat)
                begin
                    hit = 1'b1;
                end
                else if (wlo == elo)
                begin
                    if ((wla <= lat && lat <= ela) || (ela <= lat && lat <= wla))
                        hit = 1'b1;
                end
            end
            if (toggle)
                parity_bits[slot] = !parity_bits[slot];
            if (hit)
                border_bits[slot] = 1'b1;
            st.parity = parity_bits[slot];
            st.border = border_bits[slot];
            st.in_area = parity_bits[slot] | border_bits[slot];
            add_expected(st);
        endfunction

        function void check_result(logic [SLOT_W-1:0] slot, logic parity,
                                   logic border, logic in_a);
            area_status_t want;
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: slot %0d parity %b border %b in_area %b",
                             slot, parity, border, in_a);
                return;
            end
            want = expected_status.pop_front();
            if (want.slot !== slot || want.parity !== parity ||
                want.border !== border || want.in_area !== in_a)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d %b %b %b, actual %0d %b %b %b",
                             want.slot, want.parity, want.border, want.in_area,
                             slot, parity, border, in_a);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_QUERY_LAT;
    logic [COORD_W-1:0]        cfg_data = '0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      mode = MODE_SEGMENT;
    logic [SLOT_W-1:0]         area_slot = '0;
    logic signed [COORD_W-1:0] west_lon = '0;
    logic signed [COORD_W-1:0] west_lat = '0;
    logic signed [COORD_W-1:0] east_lon = '0;
    logic signed [COORD_W-1:0] east_lat = '0;
    logic                      done;
    logic [SLOT_W-1:0]         slot_out;
    logic                      crossing_parity;
    logic                      on_border;
    logic                      in_area;

    crossing_scoreboard_t board = new();
    logic signed [COORD_W-1:0] qlat = '0;
    logic signed [COORD_W-1:0] qlon = '0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    bit idle_on = 1'b1;

    point_in_polygon_crossing_table_top #(.AREA_SLOTS(AREA_SLOTS)) dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(slot_out, crossing_parity, on_border, in_area);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input logic m, input logic [SLOT_W-1:0] s,
                             input logic signed [COORD_W-1:0] wlo,
                             input logic signed [COORD_W-1:0] wla,
                             input logic signed [COORD_W-1:0] elo,
                             input logic signed [COORD_W-1:0] ela);
        bit go;
        mode <= m;
        area_slot <= s;
        west_lon <= wlo;
        west_lat <= wla;
        east_lon <= elo;
        east_lat <= ela;
        forever
        begin
            go = !(idle_on && $urandom_range(99) < 29);
            start <= go;
            @(posedge clk);
            if (go && !busy)
                break;
        end
        board.note_item(m, s, wlo, wla, elo, ela);
        items_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic write_query(input logic signed [COORD_W-1:0] lat,
                               input logic signed [COORD_W-1:0] lon);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_index <= REG_QUERY_LAT;
        cfg_data <= lat;
        @(posedge clk);
        cfg_index <= REG_QUERY_LON;
        cfg_data <= lon;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_query(lat, lon);
        qlat = lat;
        qlon = lon;
    endtask

    function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] q,
                                                       int unsigned rad);
        longint v;
        v = longint'(q) + longint'($urandom_range(2 * rad)) - longint'(rad);
        if (v > longint'(COORD_MAX))
            v = COORD_MAX;
        if (v < longint'(COORD_MIN))
            v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    function automatic int unsigned pick_radius();
        case ($urandom_range(3))
            0: return 2;
            1: return 20;
            2: return 5000;
            default: return 1 << 22;
        endcase
    endfunction

    task automatic send_ordered(input logic [SLOT_W-1:0] s,
                                input logic signed [COORD_W-1:0] alon,
                                input logic signed [COORD_W-1:0] alat,
                                input logic signed [COORD_W-1:0] blon,
                                input logic signed [COORD_W-1:0] blat);
        if (alon <= blon)
            send_item(MODE_SEGMENT, s, alon, alat, blon, blat);
        else
            send_item(MODE_SEGMENT, s, blon, blat, alon, alat);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_polygon();
        logic signed [COORD_W-1:0] plon[8];
        logic signed [COORD_W-1:0] plat[8];
        int n;
        int unsigned rad;
        logic [SLOT_W-1:0] s;
        n = $urandom_range(3, 8);
        rad = pick_radius();
        s = SLOT_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            plon[i] = ($urandom_range(9) == 0) ? qlon : near(qlon, rad);
            plat[i] = ($urandom_range(9) == 0) ? qlat : near(qlat, rad);
        end
        for (int i = 0; i < n; i++)
        begin
            int j;
            j = (i + 1) % n;
            if ($urandom_range(99) < 8)
                send_item(MODE_SEGMENT, s, plon[j], plat[j], plon[i], plat[i]);
            else
                send_ordered(s, plon[i], plat[i], plon[j], plat[j]);
        end
    endtask

    task automatic send_special();
        logic [SLOT_W-1:0] s;
        int unsigned rad;
        s = SLOT_W'($urandom);
        rad = pick_radius();
        case ($urandom_range(5))
            0: send_item(MODE_SEGMENT, s, qlon, near(qlat, rad), qlon, near(qlat, rad));
            1: send_ordered(s, near(qlon, rad), qlat, near(qlon, rad), qlat);
            2: send_ordered(s, qlon, qlat, near(qlon, rad), near(qlat, rad));
            3: send_ordered(s, near(qlon, rad), near(qlat, rad), qlon, qlat);
            4: send_item(MODE_SEGMENT, s, near(qlon, rad), near(qlat, rad),
                         near(qlon, rad), near(qlat, rad));
            default: send_ordered(s, qlon, near(qlat, rad), near(qlon, rad),
                                  near(qlat, rad));
        endcase
    endtask

    task automatic send_random_item();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 55)
            send_polygon();
        else if (kind < 72)
            send_ordered(SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        else if (kind < 77)
            send_item(MODE_SEGMENT, SLOT_W'($urandom), $urandom, $urandom, $urandom,
                      $urandom);
        else if (kind < 94)
            send_special();
        else
            send_clear();
    endtask

    initial
    begin
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lon;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_query(100, 100);
        send_item(MODE_CLEAR, 0, 0, 0, 0, 0);
        send_item(MODE_SEGMENT, 1, -10, 50, 200, 50);
        send_item(MODE_SEGMENT, 1, 100, 0, 200, 0);
        send_item(MODE_SEGMENT, 2, 0, 0, 100, 0);
        send_item(MODE_SEGMENT, 3, 0, 100, 200, 100);
        send_item(MODE_SEGMENT, 4, 100, 0, 100, 200);
        send_item(MODE_SEGMENT, 5, 100, 300, 100, 50);
        send_item(MODE_SEGMENT, 6, 100, 100, 300, 500);
        send_item(MODE_SEGMENT, 7, 0, 7, 100, 100);
        send_item(MODE_SEGMENT, 8, 0, 0, 200, 200);
        send_item(MODE_SEGMENT, 8, 0, 0, 200, 199);
        send_item(MODE_SEGMENT, 9, 98, 104, 101, 99);
        send_item(MODE_SEGMENT, 9, 99, 101, 102, 98);
        send_item(MODE_SEGMENT, 10, 200, 0, 100, 100);
        send_item(MODE_SEGMENT, 10, 200, 0, 50, 0);
        send_item(MODE_SEGMENT, 11, 100, 200, 100, 300);
        send_item(MODE_SEGMENT, 12, 0, 200, 200, 300);
        send_item(MODE_SEGMENT, 63, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
        send_item(MODE_SEGMENT, 63, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_item(MODE_SEGMENT, 62, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(MODE_SEGMENT, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(MODE_CLEAR, 63, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);

        items_sent = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lat = $urandom;
                    lon = $urandom;
                end
                1:
                begin
                    lat = COORD_MAX;
                    lon = COORD_MIN;
                end
                2:
                begin
                    lat = COORD_MIN;
                    lon = COORD_MAX;
                end
                3:
                begin
                    lat = 0;
                    lon = 0;
                end
                4:
                begin
                    lat = near(0, 5000);
                    lon = near(0, 5000);
                end
                5:
                begin
                    lat = COORD_MAX;
                    lon = COORD_MAX;
                end
                default:
                begin
                    lat = COORD_MIN;
                    lon = COORD_MIN;
                end
            endcase
            write_query(lat, lon);
            idle_on = (p != 3);
            while (items_sent < RANDOM_ITEMS * (p + 1) / PHASES)
                send_random_item();
        end

        wait_for_results();
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
